// ----- src/rrss_pkg.sv -----
// Shared types and constants for the round-robin slice scheduler.
// No dependencies; every other source file imports this package.
package rrss_pkg;

    localparam int TIME_W   = 24;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;
    localparam int JOB_W    = 4;
    localparam int REQ_W    = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SLICE   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTHING = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REJECT  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd4;

    typedef enum logic [1:0] {
        ALU_ADD_SAT,
        ALU_SUB,
        ALU_MIN
    } alu_op_t;

    typedef struct packed {
        alu_op_t             op;
        logic [TIME_W-1:0]   a;
        logic [TIME_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0]   result;
        logic                ge;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADM,
        ST_ADM_CHK,
        ST_ADM_END,
        ST_POP,
        ST_MIN,
        ST_SUBR,
        ST_ADD,
        ST_TA,
        ST_WT
    } state_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  arrival;
        logic [FIELD_W-1:0]  burst;
        logic [FIELD_W-1:0]  remaining;
    } job_rec_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [JOB_W-1:0]    job_index;
        logic [TIME_W-1:0]   slice_start;
        logic [FIELD_W-1:0]  run_length;
        logic                job_done;
        logic [TIME_W-1:0]   wait_total;
        logic [TIME_W-1:0]   turn_total;
    } result_t;

endpackage

// ----- src/rrss_alu.sv -----
// Shared 24-bit arithmetic unit: saturating add, clamped subtract, minimum.
// Depends on rrss_pkg for the request and response types.
module rrss_alu (
    input  rrss_pkg::alu_req_t req,
    output rrss_pkg::alu_rsp_t rsp
);
    import rrss_pkg::*;

    logic               sub;
    logic [TIME_W-1:0]  b_in;
    logic [TIME_W:0]    sum;
    logic               carry;

    // One adder; subtraction adds the complement plus one, so the carry out
    // means a >= b.
    assign sub   = (req.op != ALU_ADD_SAT);
    assign b_in  = sub ? ~req.b : req.b;
    assign sum   = {1'b0, req.a} + {1'b0, b_in} + {{TIME_W{1'b0}}, sub};
    assign carry = sum[TIME_W];

    always_comb
    begin
        rsp.ge = sub & carry;
        unique case (req.op)
            ALU_ADD_SAT: rsp.result = carry ? TIME_MAX : sum[TIME_W-1:0];
            ALU_SUB:     rsp.result = carry ? sum[TIME_W-1:0] : '0;
            ALU_MIN:     rsp.result = carry ? req.b : req.a;
            default:     rsp.result = '0;
        endcase
    end

endmodule

// ----- src/rrss_seq.sv -----
// Sequencer of the scheduler: job table, ready ring and the control that
// drives the shared arithmetic unit. Depends on rrss_pkg.
module rrss_seq #(
    parameter int MAX_PROCS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rrss_pkg::REQ_W-1:0]        req_type,
    input  logic [rrss_pkg::FIELD_W-1:0]      job_arrival,
    input  logic [rrss_pkg::FIELD_W-1:0]      job_burst,
    input  logic [rrss_pkg::FIELD_W-1:0]      quantum,
    output logic                              busy,
    output rrss_pkg::alu_req_t                alu_req,
    input  rrss_pkg::alu_rsp_t                alu_rsp,
    output logic                              res_valid,
    output rrss_pkg::result_t                 res
);
    import rrss_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int SUM_W = CNT_W + 1;

    state_t              state_reg, state_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [FIELD_W-1:0]  arr_reg, arr_next;
    logic [FIELD_W-1:0]  bur_reg, bur_next;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [CNT_W-1:0]    nta_reg, nta_next;
    logic [CNT_W-1:0]    fin_reg, fin_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [TIME_W-1:0]   cur_reg, cur_next;
    logic [FIELD_W-1:0]  last_arr_reg, last_arr_next;
    logic                phase_reg, phase_next;
    logic [IDX_W-1:0]    job_reg, job_next;
    logic [FIELD_W-1:0]  run_reg, run_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic                done_reg, done_next;
    logic [TIME_W-1:0]   ta_reg, ta_next;
    logic [TIME_W-1:0]   wt_reg, wt_next;

    job_rec_t            rec_mem [MAX_PROCS];
    job_rec_t            rec_rd_reg;
    logic                rec_we, rec_re;
    logic [IDX_W-1:0]    rec_waddr, rec_raddr;
    job_rec_t            rec_wdata;

    logic [IDX_W-1:0]    ring_mem [MAX_PROCS];
    logic [IDX_W-1:0]    ring_rd_reg;
    logic                ring_we, ring_re;
    logic [IDX_W-1:0]    ring_wdata;

    logic [SUM_W-1:0]    tail_sum, tail_wrap;
    logic [IDX_W-1:0]    tail_idx;
    logic [IDX_W-1:0]    res_idx;
    logic [FIELD_W-1:0]  q_eff;
    logic                ring_full;

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(MAX_PROCS)) ? tail_sum - SUM_W'(MAX_PROCS)
                                                       : tail_sum;
    assign tail_idx  = tail_wrap[IDX_W-1:0];
    assign ring_full = (count_reg >= CNT_W'(MAX_PROCS));
    assign q_eff     = (quantum == '0) ? FIELD_W'(1) : quantum;
    assign busy      = (state_reg != ST_IDLE);

    // Job table and ready ring: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rec_re)
        begin
            rec_rd_reg <= rec_mem[rec_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[tail_idx] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            loaded_reg   <= '0;
            nta_reg      <= '0;
            fin_reg      <= '0;
            count_reg    <= '0;
            head_reg     <= '0;
            cur_reg      <= '0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            nta_reg      <= nta_next;
            fin_reg      <= fin_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            cur_reg      <= cur_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        arr_reg      <= arr_next;
        bur_reg      <= bur_next;
        last_arr_reg <= last_arr_next;
        job_reg      <= job_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        done_reg     <= done_next;
        ta_reg       <= ta_next;
        wt_reg       <= wt_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        arr_next      = arr_reg;
        bur_next      = bur_reg;
        loaded_next   = loaded_reg;
        nta_next      = nta_reg;
        fin_next      = fin_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        last_arr_next = last_arr_reg;
        phase_next    = phase_reg;
        job_next      = job_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        done_next     = done_reg;
        ta_next       = ta_reg;
        wt_next       = wt_reg;

        rec_we     = 1'b0;
        rec_re     = 1'b0;
        rec_waddr  = loaded_reg[IDX_W-1:0];
        rec_raddr  = nta_reg[IDX_W-1:0];
        rec_wdata  = '{arrival: arr_reg, burst: bur_reg, remaining: bur_reg};
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_wdata = nta_reg[IDX_W-1:0];

        alu_req    = '{op: ALU_SUB, a: cur_reg, b: TIME_W'(rec_rd_reg.arrival)};

        res_valid       = 1'b0;
        res_idx         = '0;
        res.status      = STAT_NOTHING;
        res.slice_start = '0;
        res.run_length  = '0;
        res.job_done    = 1'b0;
        res.wait_total  = '0;
        res.turn_total  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    arr_next   = job_arrival;
                    bur_next   = job_burst;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (req_reg)
                    REQ_LOAD:
                    begin
                        // The adder checks the new arrival against the last one.
                        alu_req   = '{op: ALU_SUB, a: TIME_W'(arr_reg),
                                      b: TIME_W'(last_arr_reg)};
                        res_valid = 1'b1;
                        if ((loaded_reg >= CNT_W'(MAX_PROCS)) ||
                            ((loaded_reg != '0) && !alu_rsp.ge))
                        begin
                            res.status = STAT_REJECT;
                        end
                        else
                        begin
                            rec_we        = 1'b1;
                            last_arr_next = arr_reg;
                            loaded_next   = loaded_reg + 1'b1;
                            res.status    = STAT_LOADED;
                            res_idx       = loaded_reg[IDX_W-1:0];
                        end
                    end
                    REQ_CLEAR:
                    begin
                        loaded_next = '0;
                        nta_next    = '0;
                        fin_next    = '0;
                        count_next  = '0;
                        head_next   = '0;
                        cur_next    = '0;
                        res_valid   = 1'b1;
                        res.status  = STAT_CLEARED;
                    end
                    REQ_STEP:
                    begin
                        if (fin_reg >= loaded_reg)
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_NOTHING;
                        end
                        else
                        begin
                            phase_next = 1'b0;
                            state_next = ST_ADM;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_ADM:
            begin
                if (nta_reg < loaded_reg)
                begin
                    rec_re     = 1'b1;
                    state_next = ST_ADM_CHK;
                end
                else
                begin
                    state_next = ST_ADM_END;
                end
            end

            ST_ADM_CHK:
            begin
                // ge means the job has arrived; with an empty ring before the
                // slice, time jumps forward to the job's arrival instead.
                if (alu_rsp.ge || (!phase_reg && (count_reg == '0)))
                begin
                    if (!ring_full)
                    begin
                        ring_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    nta_next = nta_reg + 1'b1;
                    if (!alu_rsp.ge)
                    begin
                        cur_next = TIME_W'(rec_rd_reg.arrival);
                    end
                    state_next = ST_ADM;
                end
                else
                begin
                    state_next = ST_ADM_END;
                end
            end

            ST_ADM_END:
            begin
                if (!phase_reg)
                begin
                    if (count_reg == '0)
                    begin
                        res_valid  = 1'b1;
                        res.status = STAT_NOTHING;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ring_re    = 1'b1;
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    // Preempted job goes back to the tail after the arrivals.
                    if (!done_reg && !ring_full)
                    begin
                        ring_we    = 1'b1;
                        ring_wdata = job_reg;
                        count_next = count_reg + 1'b1;
                    end
                    res_valid       = 1'b1;
                    res.status      = STAT_SLICE;
                    res_idx         = job_reg;
                    res.slice_start = start_reg;
                    res.run_length  = run_reg;
                    res.job_done    = done_reg;
                    res.wait_total  = wt_reg;
                    res.turn_total  = ta_reg;
                    state_next      = ST_IDLE;
                end
            end

            ST_POP:
            begin
                job_next   = ring_rd_reg;
                head_next  = (head_reg == IDX_W'(MAX_PROCS - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                rec_re     = 1'b1;
                rec_raddr  = ring_rd_reg;
                state_next = ST_MIN;
            end

            ST_MIN:
            begin
                alu_req    = '{op: ALU_MIN, a: TIME_W'(rec_rd_reg.remaining),
                               b: TIME_W'(q_eff)};
                run_next   = alu_rsp.result[FIELD_W-1:0];
                state_next = ST_SUBR;
            end

            ST_SUBR:
            begin
                alu_req    = '{op: ALU_SUB, a: TIME_W'(rec_rd_reg.remaining),
                               b: TIME_W'(run_reg)};
                rec_we     = 1'b1;
                rec_waddr  = job_reg;
                rec_wdata  = '{arrival: rec_rd_reg.arrival, burst: rec_rd_reg.burst,
                               remaining: alu_rsp.result[FIELD_W-1:0]};
                done_next  = (alu_rsp.result == '0);
                ta_next    = '0;
                wt_next    = '0;
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                alu_req    = '{op: ALU_ADD_SAT, a: cur_reg, b: TIME_W'(run_reg)};
                start_next = cur_reg;
                cur_next   = alu_rsp.result;
                if (done_reg)
                begin
                    state_next = ST_TA;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = ST_ADM;
                end
            end

            ST_TA:
            begin
                alu_req    = '{op: ALU_SUB, a: cur_reg, b: TIME_W'(rec_rd_reg.arrival)};
                ta_next    = alu_rsp.result;
                state_next = ST_WT;
            end

            ST_WT:
            begin
                alu_req    = '{op: ALU_SUB, a: ta_reg, b: TIME_W'(rec_rd_reg.burst)};
                wt_next    = alu_rsp.result;
                fin_next   = fin_reg + 1'b1;
                phase_next = 1'b1;
                state_next = ST_ADM;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The job index port carries the low four bits of the table index.
        res.job_index = JOB_W'(res_idx);
    end

endmodule

// ----- src/round_robin_slice_scheduler_core.sv -----
// Round-robin slice scheduler, top level; one sequencer drives one shared adder.
// Loads, clears and steps with every job finished give their result from the decode state.
// A step that runs a slice first admits the jobs that have arrived, then runs the
// slice and, when the job completes, works out its turnaround and waiting time.
// Busy blocks the next word while a request runs, an unknown word gives no result, and done
// pulses one cycle. Reset (rst_n low, async) clears jobs, time 0 and quantum 1.
module round_robin_slice_scheduler_core #(
    parameter int MAX_PROCS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rrss_pkg::FIELD_W-1:0]      cfg_wr_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [rrss_pkg::REQ_W-1:0]        req_type,
    input  logic [rrss_pkg::FIELD_W-1:0]      job_arrival,
    input  logic [rrss_pkg::FIELD_W-1:0]      job_burst,
    output logic                              done,
    output logic [rrss_pkg::STATUS_W-1:0]     status,
    output logic [rrss_pkg::JOB_W-1:0]        job_index,
    output logic [rrss_pkg::TIME_W-1:0]       slice_start,
    output logic [rrss_pkg::FIELD_W-1:0]      run_length,
    output logic                              job_done,
    output logic [rrss_pkg::TIME_W-1:0]       wait_total,
    output logic [rrss_pkg::TIME_W-1:0]       turn_total
);
    import rrss_pkg::*;

    // The quantum register keeps its value across a clear request; only
    // reset restores it to 1. A quantum of 0 is treated as 1 downstream.
    logic [FIELD_W-1:0] quantum_reg;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    logic               res_valid;
    result_t            res;

    logic               done_reg;
    result_t            out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= FIELD_W'(1);
        end
        else if (cfg_wr_en)
        begin
            quantum_reg <= cfg_wr_data;
        end
    end

    rrss_seq #(
        .MAX_PROCS (MAX_PROCS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .job_arrival  (job_arrival),
        .job_burst    (job_burst),
        .quantum      (quantum_reg),
        .busy         (busy),
        .alu_req      (alu_req),
        .alu_rsp      (alu_rsp),
        .res_valid    (res_valid),
        .res          (res)
    );

    rrss_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // The result word is registered so the ports are glitch free; the strobe
    // lasts exactly one cycle since the sequencer emits at most one word per
    // accepted request and returns to idle after each word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign done        = done_reg;
    assign status      = out_reg.status;
    assign job_index   = out_reg.job_index;
    assign slice_start = out_reg.slice_start;
    assign run_length  = out_reg.run_length;
    assign job_done    = out_reg.job_done;
    assign wait_total  = out_reg.wait_total;
    assign turn_total  = out_reg.turn_total;

endmodule

// ----- src/rrss_checker.sv -----
// Port-level checks for the round-robin slice scheduler, bound to the top.
// Depends on rrss_pkg for the status codes.
module rrss_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              done,
    input  logic [rrss_pkg::STATUS_W-1:0]     status,
    input  logic [rrss_pkg::FIELD_W-1:0]      run_length,
    input  logic                              job_done,
    input  logic [rrss_pkg::TIME_W-1:0]       slice_start,
    input  logic [rrss_pkg::TIME_W-1:0]       wait_total,
    input  logic [rrss_pkg::TIME_W-1:0]       turn_total
);
    import rrss_pkg::*;

    // An accepted word always keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted word");

    // A result strobe is always followed by done low.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    // Only a slice result carries timing fields.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STAT_SLICE) |->
            (slice_start == '0) && (run_length == '0) && !job_done &&
            (wait_total == '0) && (turn_total == '0))
        else $error("nonzero timing fields on a non-slice result");

    // Waiting time never exceeds turnaround time for a finished job.
    a_wait_le_ta: assert property (@(posedge clk) disable iff (!rst_n)
        done && job_done |-> (wait_total <= turn_total))
        else $error("waiting time above turnaround time");

endmodule

bind round_robin_slice_scheduler_core rrss_checker u_rrss_checker (.*);
